// File: src/rfp_pkg.sv
// Shared types, constants and helpers of the reply-frame parser.
// Used by every module under response_frame_parser; depends on nothing.
package rfp_pkg;

	localparam int BUF_DEPTH   = 64;
	localparam int IDX_W       = $clog2(BUF_DEPTH);
	localparam int CNT_W       = $clog2(BUF_DEPTH + 1);
	localparam int NUM_BANKS   = 2;
	localparam int BANK_W      = $clog2(NUM_BANKS);
	localparam int MEM_DEPTH   = NUM_BANKS * BUF_DEPTH;
	localparam int PCOUNT_W    = 6;
	localparam int LEN_W       = 9;

	localparam logic [7:0] CODE_READ   = 8'h03;
	localparam logic [7:0] CODE_WRITE  = 8'h06;
	localparam logic [7:0] CODE_EXT_LO = 8'h8A;
	localparam logic [7:0] CODE_EXT_HI = 8'h8E;

	localparam logic [7:0] READ_OVERHEAD = 8'd5;
	localparam logic [7:0] WRITE_LEN     = 8'd8;
	localparam logic [7:0] EXT_MIN_LEN   = 8'd4;

	// byte positions inside a frame
	localparam logic [CNT_W-1:0] POS_STATUS   = CNT_W'(3);
	localparam logic [CNT_W-1:0] POS_ADDR_LO  = CNT_W'(3);
	localparam logic [CNT_W-1:0] POS_VALUE_HI = CNT_W'(4);
	localparam logic [CNT_W-1:0] POS_VALUE_LO = CNT_W'(5);
	localparam logic [CNT_W-1:0] READ_START   = CNT_W'(3);
	localparam logic [CNT_W-1:0] EXT_START    = CNT_W'(4);
	localparam logic [CNT_W-1:0] HEADER_LEN   = CNT_W'(3);

	typedef struct packed {
		logic [BANK_W-1:0]   bank;
		logic [7:0]          code;
		logic [PCOUNT_W-1:0] pcount;
		logic [7:0]          status;
		logic [15:0]         reg_address;
		logic [15:0]         reg_value;
		logic [15:0]         check;
	} frame_desc_t;

	typedef struct packed {
		logic                    en;
		logic [BANK_W+IDX_W-1:0] addr;
		logic [7:0]              data;
	} buf_wr_t;

	function automatic logic known_code(input logic [7:0] c);
		return (c == CODE_READ) || (c == CODE_WRITE) ||
			((c >= CODE_EXT_LO) && (c <= CODE_EXT_HI));
	endfunction

	function automatic logic [LEN_W-1:0] total_len(input logic [7:0] code,
			input logic [7:0] third);
		logic [LEN_W-1:0] len;
		if (code == CODE_READ) begin
			len = LEN_W'(third) + LEN_W'(READ_OVERHEAD);
		end else if (code == CODE_WRITE) begin
			len = LEN_W'(WRITE_LEN);
		end else if (third < EXT_MIN_LEN) begin
			len = LEN_W'(EXT_MIN_LEN);
		end else begin
			len = LEN_W'(third);
		end
		return len;
	endfunction

endpackage

// File: src/response_frame_parser.sv
// Top level of the reply-frame parser: address register, front end, descriptor
// queue and back end. Uses rfp_pkg, rfp_front, rfp_queue and rfp_back.
//
//   channel  direction  handshake              payload
//   in       to block   in_valid / in_ready    rx_byte
//   out      from block out_valid / out_ready  frame_code .. last (one payload byte)
//   cfg      to block   cfg_valid / cfg_ready  cfg_data (device address)
//
// The front end takes one received byte per cycle while a buffer bank is free.
// Each result is made in the back end by a buffer read (B_FETCH) and then a
// presentation (B_SHOW). A frame of n payload bytes gives max(n, 1) results.
// Two buffer banks let the next frame be collected while the previous drains;
// with both banks queued, in_ready drops until the older frame is fully taken.
// Reset returns to header hunting with an empty queue and address 1.
module response_frame_parser import rfp_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          rx_byte,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          frame_code,
	output logic [PCOUNT_W-1:0] payload_count,
	output logic [PCOUNT_W-1:0] byte_position,
	output logic [7:0]          payload_byte,
	output logic [7:0]          frame_status,
	output logic [15:0]         reg_address,
	output logic [15:0]         reg_value,
	output logic [15:0]         check_value,
	output logic                last,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [7:0]          cfg_data
);

	logic [7:0]  device_address_q;
	logic        q_full, q_empty, push, pop;
	frame_desc_t push_desc, head;
	buf_wr_t     buf_wr;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_address_q <= 8'h01;
		end else if (cfg_valid && cfg_ready) begin
			device_address_q <= cfg_data;
		end
	end

	rfp_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.rx_byte        (rx_byte),
		.device_address (device_address_q),
		.q_full         (q_full),
		.push           (push),
		.push_desc      (push_desc),
		.buf_wr         (buf_wr)
	);

	rfp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.pop       (pop),
		.full      (q_full),
		.empty     (q_empty),
		.head      (head)
	);

	rfp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.buf_wr        (buf_wr),
		.q_empty       (q_empty),
		.head          (head),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.frame_code    (frame_code),
		.payload_count (payload_count),
		.byte_position (byte_position),
		.payload_byte  (payload_byte),
		.frame_status  (frame_status),
		.reg_address   (reg_address),
		.reg_value     (reg_value),
		.check_value   (check_value),
		.last          (last)
	);

`ifndef SYNTHESIS
	a_show_needs_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !q_empty)
		else $error("result shown with no queued frame");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("descriptor pushed into a full queue");

	a_empty_frame_single: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && payload_count == '0) |-> (last && payload_byte == 8'h00 &&
		byte_position == '0))
		else $error("empty frame not reported as one final result");

	a_position_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && payload_count != '0) |-> (byte_position < payload_count))
		else $error("byte position beyond payload count");
`endif

endmodule

// File: src/rfp_front.sv
// Front end: hunts for a frame header, collects the frame, writes payload bytes
// into the frame buffer and hands a frame descriptor to the queue. Uses rfp_pkg.
module rfp_front import rfp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	input  logic [7:0]  device_address,
	input  logic        q_full,
	output logic        push,
	output frame_desc_t push_desc,
	output buf_wr_t     buf_wr
);

	typedef enum logic [1:0] {
		PH_HUNT    = 2'b01,
		PH_COLLECT = 2'b10
	} phase_t;

	phase_t             phase_q;
	logic [7:0]         recent0_q, recent1_q;
	logic [CNT_W-1:0]   count_q;
	logic [7:0]         kind_q, len_q;
	logic [7:0]         prev_q, status_q;
	logic [15:0]        reg_address_q, reg_value_q;
	logic [BANK_W-1:0]  wbank_q;

	logic               accept, hit, done, is_read, is_write;
	logic [CNT_W-1:0]   cnt_next, start;
	logic [7:0]         status_n;
	logic [LEN_W-1:0]   hdr_len;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign is_read  = (kind_q == CODE_READ);
	assign is_write = (kind_q == CODE_WRITE);

	assign hdr_len  = total_len(recent0_q, rx_byte);
	assign hit      = (recent1_q == device_address) && known_code(recent0_q) &&
		(hdr_len <= LEN_W'(BUF_DEPTH));
	assign cnt_next = count_q + CNT_W'(1);
	assign done     = (phase_q == PH_COLLECT) &&
		(LEN_W'(cnt_next) >= total_len(kind_q, len_q));
	assign status_n = (count_q == POS_STATUS) ? rx_byte : status_q;
	assign start    = is_read ? READ_START : EXT_START;

	// payload (and harmless trailing) bytes go to the buffer at offset from start
	always_comb begin
		buf_wr.en   = accept && (phase_q == PH_COLLECT) && !is_write && (count_q >= start);
		buf_wr.addr = {wbank_q, IDX_W'(count_q - start)};
		buf_wr.data = rx_byte;
	end

	always_comb begin
		push_desc.bank        = wbank_q;
		push_desc.code        = kind_q;
		push_desc.pcount      = '0;
		push_desc.status      = '0;
		push_desc.reg_address = '0;
		push_desc.reg_value   = '0;
		push_desc.check       = {rx_byte, prev_q};
		if (is_read) begin
			push_desc.pcount = PCOUNT_W'(len_q);
		end else if (is_write) begin
			push_desc.reg_address = reg_address_q;
			push_desc.reg_value   = reg_value_q;
		end else begin
			push_desc.pcount = (len_q > READ_OVERHEAD) ?
				PCOUNT_W'(len_q - READ_OVERHEAD) : '0;
			push_desc.status = status_n;
			push_desc.check  = {8'h00, rx_byte};
		end
	end

	assign push = accept && done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HUNT;
			recent0_q <= '0;
			recent1_q <= '0;
			count_q   <= '0;
			kind_q    <= '0;
			len_q     <= '0;
			wbank_q   <= '0;
		end else if (accept) begin
			case (phase_q)
				PH_HUNT: begin
					if (hit) begin
						phase_q <= PH_COLLECT;
						count_q <= HEADER_LEN;
						kind_q  <= recent0_q;
						len_q   <= rx_byte;
					end else begin
						recent1_q <= recent0_q;
						recent0_q <= rx_byte;
					end
				end
				PH_COLLECT: begin
					count_q <= cnt_next;
					if (done) begin
						phase_q   <= PH_HUNT;
						recent0_q <= '0;
						recent1_q <= '0;
						count_q   <= '0;
						wbank_q   <= wbank_q + BANK_W'(1);
					end
				end
				default: begin
					phase_q <= PH_HUNT;
				end
			endcase
		end
	end

	// field capture, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			prev_q   <= rx_byte;
			status_q <= status_n;
			if (phase_q == PH_HUNT) begin
				reg_address_q[15:8] <= rx_byte;
			end else begin
				if (count_q == POS_ADDR_LO) reg_address_q[7:0] <= rx_byte;
				if (count_q == POS_VALUE_HI) reg_value_q[15:8] <= rx_byte;
				if (count_q == POS_VALUE_LO) reg_value_q[7:0] <= rx_byte;
			end
		end
	end

endmodule

// File: src/rfp_queue.sv
// Two-entry descriptor queue between front and back, one entry per buffer bank.
// Uses rfp_pkg.
module rfp_queue import rfp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  frame_desc_t push_desc,
	input  logic        pop,
	output logic        full,
	output logic        empty,
	output frame_desc_t head
);

	frame_desc_t        entry_q [NUM_BANKS];
	logic [BANK_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [BANK_W:0]    cnt_q;

	assign full  = (cnt_q == (BANK_W+1)'(NUM_BANKS));
	assign empty = (cnt_q == '0);
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + BANK_W'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + BANK_W'(1);
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + (BANK_W+1)'(1);
				2'b01:   cnt_q <= cnt_q - (BANK_W+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_desc;
	end

endmodule

// File: src/rfp_back.sv
// Back end: holds the banked frame buffer and drains one queued frame as a
// sequence of payload results. Uses rfp_pkg.
module rfp_back import rfp_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  buf_wr_t             buf_wr,
	input  logic                q_empty,
	input  frame_desc_t         head,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          frame_code,
	output logic [PCOUNT_W-1:0] payload_count,
	output logic [PCOUNT_W-1:0] byte_position,
	output logic [7:0]          payload_byte,
	output logic [7:0]          frame_status,
	output logic [15:0]         reg_address,
	output logic [15:0]         reg_value,
	output logic [15:0]         check_value,
	output logic                last
);

	typedef enum logic [2:0] {
		B_IDLE  = 3'b001,
		B_FETCH = 3'b010,
		B_SHOW  = 3'b100
	} back_state_t;

	logic [7:0]          mem [MEM_DEPTH];
	logic [7:0]          rdata_q;
	back_state_t         state_q;
	logic [PCOUNT_W-1:0] pos_q;
	logic                is_last;

	assign is_last = (head.pcount == '0) || ((pos_q + PCOUNT_W'(1)) == head.pcount);

	always_ff @(posedge clk) begin
		if (buf_wr.en) mem[buf_wr.addr] <= buf_wr.data;
		rdata_q <= mem[{head.bank, IDX_W'(pos_q)}];
	end

	assign out_valid     = (state_q == B_SHOW);
	assign pop           = out_valid && out_ready && is_last;
	assign frame_code    = head.code;
	assign payload_count = head.pcount;
	assign byte_position = pos_q;
	assign payload_byte  = (head.pcount == '0) ? 8'h00 : rdata_q;
	assign frame_status  = head.status;
	assign reg_address   = head.reg_address;
	assign reg_value     = head.reg_value;
	assign check_value   = head.check;
	assign last          = is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			pos_q   <= '0;
		end else begin
			case (state_q)
				B_IDLE: begin
					pos_q <= '0;
					if (!q_empty) state_q <= B_FETCH;
				end
				B_FETCH: begin
					state_q <= B_SHOW;
				end
				B_SHOW: begin
					if (out_ready) begin
						if (is_last) begin
							state_q <= B_IDLE;
						end else begin
							pos_q   <= pos_q + PCOUNT_W'(1);
							state_q <= B_FETCH;
						end
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

endmodule
